>>> rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/drrip_pkg.sv
package drrip_pkg;

  // Default geometry and policy sizes.
  localparam int SETS_DEFAULT              = 2048;
  localparam int WAYS_DEFAULT              = 16;
  localparam int LEADER_SETS_DEFAULT       = 32;
  localparam int SELECTOR_BITS_DEFAULT     = 10;
  localparam int DECAY_PERIOD_LOG2_DEFAULT = 12;

  // Fixed field widths.
  localparam int SET_INDEX_W = 11;
  localparam int WAY_INDEX_W = 4;
  localparam int MIN_SETS_LOG2 = 6;
  // Number of conditional subtract steps that fold the set index into range.
  localparam int SET_FOLD_STEPS = SET_INDEX_W - MIN_SETS_LOG2 + 1;

  // Re-reference and dead-counter codes.
  localparam logic [1:0] RRPV_NEAR    = 2'd2;
  localparam logic [1:0] RRPV_DISTANT = 2'd3;
  localparam logic [1:0] RRPV_HIT     = 2'd0;
  localparam logic [1:0] DEAD_LIMIT   = 2'd3;
  localparam logic [1:0] DEAD_CLEAR   = 2'd0;

  // Request modes.
  localparam logic MODE_VICTIM = 1'b0;
  localparam logic MODE_UPDATE = 1'b1;

  // Random source for bimodal insertion.
  localparam logic [15:0] LFSR_SEED = 16'hACE1;
  localparam logic [15:0] LFSR_TAPS = 16'hB400;
  localparam int BRRIP_NEAR_BITS = 5;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECAY_RD,
    ST_DECAY_WR,
    ST_READ,
    ST_MODIFY
  } state_t;

  typedef enum logic [1:0] {
    RD_INPUT,
    RD_SET,
    RD_SWEEP
  } rd_src_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_CLEAR,
    WR_DECAY,
    WR_ROW
  } wr_kind_t;

  typedef struct packed {
    logic     accept;
    logic     rd_en;
    rd_src_t  rd_src;
    wr_kind_t wr_kind;
    logic     sweep_step;
    logic     emit;
  } dp_cmd_t;

  typedef struct packed {
    logic decay_due;
    logic sweep_last;
  } dp_status_t;

endpackage

>>> rtl/drrip_ctrl.sv
module drrip_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  drrip_pkg::dp_status_t status,
  output drrip_pkg::dp_cmd_t    cmd,
  output logic                  busy
);

  drrip_pkg::state_t state;
  drrip_pkg::state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= drrip_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next     = state;
    cmd.accept     = 1'b0;
    cmd.rd_en      = 1'b0;
    cmd.rd_src     = drrip_pkg::RD_INPUT;
    cmd.wr_kind    = drrip_pkg::WR_NONE;
    cmd.sweep_step = 1'b0;
    cmd.emit       = 1'b0;
    busy           = 1'b1;
    unique case (state)
      drrip_pkg::ST_CLEAR: begin
        cmd.wr_kind    = drrip_pkg::WR_CLEAR;
        cmd.sweep_step = 1'b1;
        if (status.sweep_last) begin
          state_next = drrip_pkg::ST_IDLE;
        end
      end
      drrip_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.accept = 1'b1;
          cmd.rd_en  = 1'b1;
          cmd.rd_src = drrip_pkg::RD_INPUT;
          if (status.decay_due) begin
            state_next = drrip_pkg::ST_DECAY_RD;
          end else begin
            state_next = drrip_pkg::ST_MODIFY;
          end
        end
      end
      drrip_pkg::ST_DECAY_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_src = drrip_pkg::RD_SWEEP;
        state_next = drrip_pkg::ST_DECAY_WR;
      end
      drrip_pkg::ST_DECAY_WR: begin
        cmd.wr_kind    = drrip_pkg::WR_DECAY;
        cmd.sweep_step = 1'b1;
        if (status.sweep_last) begin
          state_next = drrip_pkg::ST_READ;
        end else begin
          state_next = drrip_pkg::ST_DECAY_RD;
        end
      end
      drrip_pkg::ST_READ: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_src = drrip_pkg::RD_SET;
        state_next = drrip_pkg::ST_MODIFY;
      end
      drrip_pkg::ST_MODIFY: begin
        cmd.wr_kind = drrip_pkg::WR_ROW;
        cmd.emit    = 1'b1;
        state_next  = drrip_pkg::ST_IDLE;
      end
      default: begin
        state_next = drrip_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/drrip_dpath.sv
module drrip_dpath #(
  parameter int SETS              = drrip_pkg::SETS_DEFAULT,
  parameter int WAYS              = drrip_pkg::WAYS_DEFAULT,
  parameter int LEADER_SETS       = drrip_pkg::LEADER_SETS_DEFAULT,
  parameter int SELECTOR_BITS     = drrip_pkg::SELECTOR_BITS_DEFAULT,
  parameter int DECAY_PERIOD_LOG2 = drrip_pkg::DECAY_PERIOD_LOG2_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  drrip_pkg::dp_cmd_t                  cmd,
  output drrip_pkg::dp_status_t               status,
  input  logic                                mode,
  input  logic [drrip_pkg::SET_INDEX_W-1:0]   set_index,
  input  logic [drrip_pkg::WAY_INDEX_W-1:0]   way_index,
  input  logic                                was_hit,
  output logic [drrip_pkg::WAY_INDEX_W-1:0]   victim_way,
  output logic                                used_fallback,
  output logic                                done
);

  localparam int SW    = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int ROW_W = 4 * WAYS;
  localparam logic [SELECTOR_BITS-1:0] SEL_MAX = '1;
  localparam logic [SELECTOR_BITS-1:0] SEL_MID = SEL_MAX >> 1;

  // Row memory: low half holds the re-reference values, high half the dead counters.
  logic [ROW_W-1:0] row_mem [SETS];
  logic [ROW_W-1:0] rd_data;
  logic [SW-1:0]    rd_addr;
  logic [SW-1:0]    wr_addr;
  logic [ROW_W-1:0] wr_data;
  logic             wr_en;

  // Latched request and policy state.
  logic                         mode_r;
  logic [SW-1:0]                set_r;
  logic [drrip_pkg::WAY_INDEX_W-1:0] way_r;
  logic                         hit_r;
  logic [DECAY_PERIOD_LOG2-1:0] count;
  logic [DECAY_PERIOD_LOG2-1:0] count_inc;
  logic [SELECTOR_BITS-1:0]     selector;
  logic [SELECTOR_BITS-1:0]     selector_next;
  logic [15:0]                  lfsr;
  logic [15:0]                  lfsr_stepped;
  logic                         lfsr_use;
  logic [SW-1:0]                sweep;
  logic                         sweep_last;

  // Row views and computed rows.
  logic [1:0]       rrpv [WAYS];
  logic [1:0]       dead [WAYS];
  logic [1:0]       aged [WAYS];
  logic [ROW_W-1:0] aged_row;
  logic [ROW_W-1:0] decay_row;
  logic [ROW_W-1:0] clear_row;
  logic [ROW_W-1:0] modify_row;
  logic             found0;
  logic             found1;
  logic [WW-1:0]    idx0;
  logic [WW-1:0]    idx1;
  logic [WW-1:0]    victim_idx;
  logic             fallback;
  logic [WW-1:0]    way_sel;
  logic [31:0]      way_wide;
  logic [31:0]      victim_wide;
  logic             way_ok;
  logic             srrip_leader;
  logic             brrip_leader;
  logic [1:0]       dead_bumped;
  logic [1:0]       ins;

  // Fold the incoming set index into range by conditional subtracts of shifted set counts.
  function automatic logic [SW-1:0] fold_set(input logic [drrip_pkg::SET_INDEX_W-1:0] idx);
    logic [31:0] x;
    x = 32'(idx);
    for (int k = drrip_pkg::SET_FOLD_STEPS - 1; k >= 0; k--) begin
      if (x >= (32'(SETS) << k)) begin
        x = x - (32'(SETS) << k);
      end
    end
    return x[SW-1:0];
  endfunction

  // Status back to the controller.
  assign count_inc         = DECAY_PERIOD_LOG2'(count + 1'b1);
  assign sweep_last        = (32'(sweep) == 32'(SETS - 1));
  assign status.decay_due  = (mode == drrip_pkg::MODE_UPDATE) && (count_inc == '0);
  assign status.sweep_last = sweep_last;

  // Read and write address selection.
  always_comb begin
    unique case (cmd.rd_src)
      drrip_pkg::RD_INPUT: rd_addr = fold_set(set_index);
      drrip_pkg::RD_SET:   rd_addr = set_r;
      drrip_pkg::RD_SWEEP: rd_addr = sweep;
      default:             rd_addr = set_r;
    endcase
  end

  assign wr_addr = (cmd.wr_kind == drrip_pkg::WR_ROW) ? set_r : sweep;
  assign wr_en   = (cmd.wr_kind != drrip_pkg::WR_NONE);

  always_comb begin
    unique case (cmd.wr_kind)
      drrip_pkg::WR_CLEAR: wr_data = clear_row;
      drrip_pkg::WR_DECAY: wr_data = decay_row;
      drrip_pkg::WR_ROW:   wr_data = modify_row;
      default:             wr_data = rd_data;
    endcase
  end

  // Row memory with registered read data.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      row_mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data <= row_mem[rd_addr];
    end
  end

  // Split the row, and build the aged, decayed and cleared rows.
  always_comb begin
    aged_row  = rd_data;
    decay_row = rd_data;
    clear_row = '0;
    for (int w = 0; w < WAYS; w++) begin
      rrpv[w] = rd_data[2*w +: 2];
      dead[w] = rd_data[2*WAYS + 2*w +: 2];
      aged[w] = (rrpv[w] == drrip_pkg::RRPV_DISTANT) ? rrpv[w] : 2'(rrpv[w] + 2'd1);
      aged_row[2*w +: 2] = aged[w];
      decay_row[2*WAYS + 2*w +: 2] = (dead[w] != 2'd0) ? 2'(dead[w] - 2'd1) : dead[w];
      clear_row[2*w +: 2] = drrip_pkg::RRPV_DISTANT;
      clear_row[2*WAYS + 2*w +: 2] = drrip_pkg::DEAD_CLEAR;
    end
  end

  // First distant way, before and after one aging step.
  always_comb begin
    found0 = 1'b0;
    found1 = 1'b0;
    idx0   = '0;
    idx1   = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (rrpv[w] == drrip_pkg::RRPV_DISTANT) begin
        found0 = 1'b1;
        idx0   = WW'(w);
      end
      if (aged[w] == drrip_pkg::RRPV_DISTANT) begin
        found1 = 1'b1;
        idx1   = WW'(w);
      end
    end
  end

  // Way and set role decoding.
  assign way_wide     = 32'(way_r);
  assign way_sel      = way_wide[WW-1:0];
  assign way_ok       = (way_wide < 32'(WAYS));
  assign srrip_leader = (32'(set_r) < 32'(LEADER_SETS));
  assign brrip_leader = !srrip_leader && ((32'(set_r) + 32'(LEADER_SETS)) >= 32'(SETS));
  assign lfsr_stepped = (lfsr >> 1) ^ (lfsr[0] ? drrip_pkg::LFSR_TAPS : 16'h0000);

  // Victim choice and access update on the row just read.
  always_comb begin
    modify_row    = rd_data;
    victim_idx    = '0;
    fallback      = 1'b0;
    selector_next = selector;
    lfsr_use      = 1'b0;
    dead_bumped   = dead[way_sel];
    ins           = drrip_pkg::RRPV_NEAR;
    if (mode_r == drrip_pkg::MODE_VICTIM) begin
      if (found0) begin
        victim_idx = idx0;
      end else begin
        modify_row = aged_row;
        if (found1) begin
          victim_idx = idx1;
        end else begin
          fallback = 1'b1;
        end
      end
    end else if (hit_r) begin
      if (way_ok) begin
        modify_row[2*way_sel +: 2]          = drrip_pkg::RRPV_HIT;
        modify_row[2*WAYS + 2*way_sel +: 2] = drrip_pkg::DEAD_CLEAR;
      end
      if (srrip_leader) begin
        if (selector != SEL_MAX) begin
          selector_next = SELECTOR_BITS'(selector + 1'b1);
        end
      end else if (brrip_leader) begin
        if (selector != '0) begin
          selector_next = SELECTOR_BITS'(selector - 1'b1);
        end
      end
    end else if (way_ok) begin
      if ((rrpv[way_sel] == drrip_pkg::RRPV_DISTANT) && (dead[way_sel] != drrip_pkg::DEAD_LIMIT)) begin
        dead_bumped = 2'(dead[way_sel] + 2'd1);
      end
      if (dead_bumped == drrip_pkg::DEAD_LIMIT) begin
        ins = drrip_pkg::RRPV_DISTANT;
      end else if (srrip_leader) begin
        ins = drrip_pkg::RRPV_NEAR;
      end else if (!brrip_leader && (selector >= SEL_MID)) begin
        ins = drrip_pkg::RRPV_NEAR;
      end else begin
        lfsr_use = 1'b1;
        ins = (lfsr_stepped[drrip_pkg::BRRIP_NEAR_BITS-1:0] == '0) ?
              drrip_pkg::RRPV_NEAR : drrip_pkg::RRPV_DISTANT;
      end
      modify_row[2*way_sel +: 2]          = ins;
      modify_row[2*WAYS + 2*way_sel +: 2] = dead_bumped;
    end
  end

  assign victim_wide = 32'(victim_idx);

  // Request capture and result beat.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_r <= mode;
      set_r  <= fold_set(set_index);
      way_r  <= way_index;
      hit_r  <= was_hit;
    end
    if (cmd.emit) begin
      victim_way    <= victim_wide[drrip_pkg::WAY_INDEX_W-1:0];
      used_fallback <= fallback;
    end
  end

  // Policy state, sweep counter and result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      selector <= SEL_MID;
      lfsr     <= drrip_pkg::LFSR_SEED;
      sweep    <= '0;
      done     <= 1'b0;
    end else begin
      done <= cmd.emit;
      if (cmd.accept && (mode == drrip_pkg::MODE_UPDATE)) begin
        count <= count_inc;
      end
      if (cmd.emit) begin
        selector <= selector_next;
        if (lfsr_use) begin
          lfsr <= lfsr_stepped;
        end
      end
      if (cmd.sweep_step) begin
        sweep <= sweep_last ? '0 : SW'(sweep + 1'b1);
      end
    end
  end

endmodule

>>> rtl/drrip_dead_block_replacement_core.sv
// Channel   Handshake             Fields
// request   start high, busy low  mode, set_index, way_index, was_hit
// result    done, one cycle       victim_way, used_fallback
//
// A request reads its set's row from the row memory when it is accepted, then
// modifies and writes it back; the result beat follows on done in the next cycle.
// Every 2^DECAY_PERIOD_LOG2-th update first walks all SETS rows to decay the dead
// counters, reading and writing each row in turn, then rereads its own set's row.
// After reset a clearing pass writes every row with busy held high.
// The result beat cannot be stalled; busy alone holds requests off.
module drrip_dead_block_replacement_core #(
  parameter int SETS              = drrip_pkg::SETS_DEFAULT,
  parameter int WAYS              = drrip_pkg::WAYS_DEFAULT,
  parameter int LEADER_SETS       = drrip_pkg::LEADER_SETS_DEFAULT,
  parameter int SELECTOR_BITS     = drrip_pkg::SELECTOR_BITS_DEFAULT,
  parameter int DECAY_PERIOD_LOG2 = drrip_pkg::DECAY_PERIOD_LOG2_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              mode,
  input  logic [drrip_pkg::SET_INDEX_W-1:0] set_index,
  input  logic [drrip_pkg::WAY_INDEX_W-1:0] way_index,
  input  logic                              was_hit,
  output logic [drrip_pkg::WAY_INDEX_W-1:0] victim_way,
  output logic                              used_fallback,
  output logic                              done
);

  drrip_pkg::dp_cmd_t    cmd;
  drrip_pkg::dp_status_t status;

  // Sequencer.
  drrip_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // Row memory and policy state.
  drrip_dpath #(
    .SETS              (SETS),
    .WAYS              (WAYS),
    .LEADER_SETS       (LEADER_SETS),
    .SELECTOR_BITS     (SELECTOR_BITS),
    .DECAY_PERIOD_LOG2 (DECAY_PERIOD_LOG2)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .mode          (mode),
    .set_index     (set_index),
    .way_index     (way_index),
    .was_hit       (was_hit),
    .victim_way    (victim_way),
    .used_fallback (used_fallback),
    .done          (done)
  );

endmodule

>>> rtl/drrip_chk.sv
`include "assert_macros.svh"

module drrip_chk (
  input logic                              clk,
  input logic                              rst,
  input logic                              start,
  input logic                              busy,
  input logic [drrip_pkg::WAY_INDEX_W-1:0] victim_way,
  input logic                              used_fallback,
  input logic                              done
);

  // An accepted request keeps the block busy in the next cycle.
  `ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy, "accept did not raise busy")

  // A result beat lasts exactly one cycle.
  `ASSERT_NEXT(a_done_single, clk, rst, done, !done, "result beat longer than one cycle")

  // The result beat appears only once the block is free again.
  `ASSERT_SAME(a_done_idle, clk, rst, done, !busy, "result beat while busy")

  // A fallback answer always names way zero.
  `ASSERT_SAME(a_fallback_way, clk, rst, done && used_fallback, victim_way == '0,
    "fallback with nonzero way")

endmodule

bind drrip_dead_block_replacement_core drrip_chk u_chk (.*);

>>> verif/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int SETS              = drrip_pkg::SETS_DEFAULT;
  localparam int WAYS              = drrip_pkg::WAYS_DEFAULT;
  localparam int LEADER_SETS       = drrip_pkg::LEADER_SETS_DEFAULT;
  localparam int SELECTOR_BITS     = drrip_pkg::SELECTOR_BITS_DEFAULT;
  localparam int DECAY_PERIOD_LOG2 = drrip_pkg::DECAY_PERIOD_LOG2_DEFAULT;
  localparam int SET_INDEX_W       = drrip_pkg::SET_INDEX_W;
  localparam int WAY_INDEX_W       = drrip_pkg::WAY_INDEX_W;
  localparam int unsigned SEL_MAX  = (1 << SELECTOR_BITS) - 1;
  localparam int CYCLE_LIMIT       = 600000;
  localparam int PHASE_BEATS       = 230;

  // Sets that the random traffic keeps returning to: both leader groups,
  // their boundaries, and a few followers.
  localparam logic [SET_INDEX_W-1:0] HOT_SETS [8] = '{
    11'd0, 11'd31, 11'd32, 11'd1023, 11'd1400, 11'd2015, 11'd2016, 11'd2047
  };

  // Sender idle percentage per phase; results can never be held off, so the
  // receiver-side phases reduce to plain streaming.
  localparam int PHASE_IDLE [4] = '{0, 85, 0, 31};

  typedef struct packed {
    logic [WAY_INDEX_W-1:0] way;
    logic                   fallback;
  } choice_t;

  typedef struct packed {
    logic                   op;
    logic [SET_INDEX_W-1:0] set_no;
    logic [WAY_INDEX_W-1:0] way_no;
    logic                   hit;
    logic [WAY_INDEX_W-1:0] want_way;
    logic                   want_fb;
  } probe_t;

  logic                   clk;
  logic                   rst;
  logic                   start;
  logic                   busy;
  logic                   mode;
  logic [SET_INDEX_W-1:0] set_index;
  logic [WAY_INDEX_W-1:0] way_index;
  logic                   was_hit;
  logic [WAY_INDEX_W-1:0] victim_way;
  logic                   used_fallback;
  logic                   done;

  // Mirror of the replacement state.
  logic [1:0]                   rrpv_mirror [SETS*WAYS];
  logic [1:0]                   dead_mirror [SETS*WAYS];
  int unsigned                  psel;
  logic [DECAY_PERIOD_LOG2-1:0] upd_count;
  logic [15:0]                  lfsr;

  choice_t                pending_choices [$];
  logic [WAY_INDEX_W-1:0] last_victim;
  int                     idle_pct;
  int                     beats_sent;
  int                     mism_count;
  int                     cycle_count;
  bit                     floor_seen;

  // Directed beats: extremes of every field, both modes, aging to fallback,
  // and insertion in each kind of set. Updates always answer zero.
  probe_t directed_probes [26] = '{
    '{drrip_pkg::MODE_VICTIM, 11'd0,    4'd0,  1'b0, 4'd0, 1'b0},
    '{drrip_pkg::MODE_VICTIM, 11'd2047, 4'd15, 1'b1, 4'd0, 1'b0},
    '{drrip_pkg::MODE_UPDATE, 11'd5,    4'd0,  1'b1, 4'd0, 1'b0},
    '{drrip_pkg::MODE_UPDATE, 11'd5,    4'd1,  1'b1, 4'd0, 1'b0},
    '{drrip_pkg::MODE_UPDATE, 11'd5,    4'd2,  1'b1, 4'd0, 1'b0},
    '{drrip_pkg::MODE_UPDATE, 11'd5,    4'd3,  1'b1, 4'd0, 1'b0},
    '{drrip_pkg::MODE_UPDATE, 11'd5,    4'd4,  1'b1, 4'd0, 1'b0},
    '{drrip_pkg::MODE_UPDATE, 11'd5,    4'd5,  1'b1, 4'd0, 1'b0},
    '{drrip_pkg::MODE_UPDATE, 11'd5,    4'd6,  1'b1, 4'd0, 1'b0},
    '{drrip_pkg::MODE_UPDATE, 11'd5,    4'd7,  1'b1, 4'd0, 1'b0},
    '{drrip_pkg::MODE_UPDATE, 11'd5,    4'd8,  1'b1, 4'd0, 1'b0},
    '{drrip_pkg::MODE_UPDATE, 11'd5,    4'd9,  1'b1, 4'd0, 1'b0},
    '{drrip_pkg::MODE_UPDATE, 11'd5,    4'd10, 1'b1, 4'd0, 1'b0},
    '{drrip_pkg::MODE_UPDATE, 11'd5,    4'd11, 1'b1, 4'd0, 1'b0},
    '{drrip_pkg::MODE_UPDATE, 11'd5,    4'd12, 1'b1, 4'd0, 1'b0},
    '{drrip_pkg::MODE_UPDATE, 11'd5,    4'd13, 1'b1, 4'd0, 1'b0},
    '{drrip_pkg::MODE_UPDATE, 11'd5,    4'd14, 1'b1, 4'd0, 1'b0},
    '{drrip_pkg::MODE_UPDATE, 11'd5,    4'd15, 1'b1, 4'd0, 1'b0},
    '{drrip_pkg::MODE_VICTIM, 11'd5,    4'd0,  1'b0, 4'd0, 1'b1},
    '{drrip_pkg::MODE_VICTIM, 11'd5,    4'd0,  1'b0, 4'd0, 1'b1},
    '{drrip_pkg::MODE_VICTIM, 11'd5,    4'd0,  1'b0, 4'd0, 1'b0},
    '{drrip_pkg::MODE_UPDATE, 11'd0,    4'd15, 1'b0, 4'd0, 1'b0},
    '{drrip_pkg::MODE_UPDATE, 11'd2047, 4'd15, 1'b0, 4'd0, 1'b0},
    '{drrip_pkg::MODE_UPDATE, 11'd1000, 4'd7,  1'b0, 4'd0, 1'b0},
    '{drrip_pkg::MODE_UPDATE, 11'd2047, 4'd9,  1'b1, 4'd0, 1'b0},
    '{drrip_pkg::MODE_VICTIM, 11'd1000, 4'd0,  1'b0, 4'd0, 1'b0}
  };

  drrip_dead_block_replacement_core dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .mode          (mode),
    .set_index     (set_index),
    .way_index     (way_index),
    .was_hit       (was_hit),
    .victim_way    (victim_way),
    .used_fallback (used_fallback),
    .done          (done)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // First way of a set whose block is at the distant value.
  function automatic bit find_distant_way(input int unsigned base,
                                          output logic [WAY_INDEX_W-1:0] way);
    int unsigned i;
    way = '0;
    for (i = 0; i < WAYS; i++) begin
      if (rrpv_mirror[base + i] == drrip_pkg::RRPV_DISTANT) begin
        way = WAY_INDEX_W'(i);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Bimodal draw: step the Galois LFSR, near only when its low bits are zero.
  function automatic logic [1:0] brrip_insertion();
    logic lsb;
    lsb  = lfsr[0];
    lfsr = lfsr >> 1;
    if (lsb) begin
      lfsr = lfsr ^ drrip_pkg::LFSR_TAPS;
    end
    return (lfsr[drrip_pkg::BRRIP_NEAR_BITS-1:0] == '0) ?
           drrip_pkg::RRPV_NEAR : drrip_pkg::RRPV_DISTANT;
  endfunction

  // Applies one request beat to the mirror and returns the answer it earns.
  function automatic void predict_replacement(input logic op,
                                              input logic [SET_INDEX_W-1:0] set_no,
                                              input logic [WAY_INDEX_W-1:0] way_no,
                                              input logic hit,
                                              output choice_t res);
    int unsigned s;
    int unsigned base;
    int unsigned idx;
    int unsigned i;
    bit srrip_ldr;
    bit brrip_ldr;
    logic [1:0] ins;
    logic [WAY_INDEX_W-1:0] vway;
    res = '0;
    s = set_no % SETS;
    base = s * WAYS;
    idx = base + way_no;
    srrip_ldr = (s < LEADER_SETS);
    brrip_ldr = !srrip_ldr && (s + LEADER_SETS >= SETS);

    // Victim search, aging the set once when nothing is distant.
    if (op == drrip_pkg::MODE_VICTIM) begin
      if (!find_distant_way(base, vway)) begin
        for (i = 0; i < WAYS; i++) begin
          if (rrpv_mirror[base + i] != drrip_pkg::RRPV_DISTANT) begin
            rrpv_mirror[base + i] = rrpv_mirror[base + i] + 2'd1;
          end
        end
        if (!find_distant_way(base, vway)) begin
          vway = '0;
          res.fallback = 1'b1;
        end
      end
      res.way = vway;
      return;
    end

    // The update count wraps first; decay then precedes this beat's update.
    upd_count = upd_count + 1'b1;
    if (upd_count == '0) begin
      for (i = 0; i < SETS * WAYS; i++) begin
        if (dead_mirror[i] != drrip_pkg::DEAD_CLEAR) begin
          dead_mirror[i] = dead_mirror[i] - 2'd1;
        end
      end
    end

    // Hits promote the block and steer the selector in leader sets.
    if (hit) begin
      if (way_no < WAYS) begin
        rrpv_mirror[idx] = drrip_pkg::RRPV_HIT;
        dead_mirror[idx] = drrip_pkg::DEAD_CLEAR;
      end
      if (srrip_ldr) begin
        if (psel < SEL_MAX) psel++;
      end else if (brrip_ldr) begin
        if (psel > 0) psel--;
      end
      if (psel == 0) floor_seen = 1'b1;
      return;
    end

    // Miss fill: train the dead counter, then pick the insertion value.
    if (way_no < WAYS) begin
      if (rrpv_mirror[idx] == drrip_pkg::RRPV_DISTANT &&
          dead_mirror[idx] < drrip_pkg::DEAD_LIMIT) begin
        dead_mirror[idx] = dead_mirror[idx] + 2'd1;
      end
      if (dead_mirror[idx] == drrip_pkg::DEAD_LIMIT) begin
        ins = drrip_pkg::RRPV_DISTANT;
      end else if (srrip_ldr) begin
        ins = drrip_pkg::RRPV_NEAR;
      end else if (brrip_ldr) begin
        ins = brrip_insertion();
      end else if (psel >= SEL_MAX / 2) begin
        ins = drrip_pkg::RRPV_NEAR;
      end else begin
        ins = brrip_insertion();
      end
      rrpv_mirror[idx] = ins;
    end
  endfunction

  // Offers one request beat after a random idle gap and waits for acceptance.
  task automatic send_beat(input logic op, input logic [SET_INDEX_W-1:0] set_no,
                           input logic [WAY_INDEX_W-1:0] way_no, input logic hit,
                           input bit typed, input choice_t typed_res);
    int gap;
    choice_t res;
    gap = 0;
    while (idle_pct != 0 && $urandom_range(99) < idle_pct && gap < 30) gap++;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    mode      <= op;
    set_index <= set_no;
    way_index <= way_no;
    was_hit   <= hit;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    predict_replacement(op, set_no, way_no, hit, res);
    last_victim = res.way;
    pending_choices.push_back(typed ? typed_res : res);
    beats_sent++;
  endtask

  // One cache access: a hit, or a victim request followed by its fill;
  // a few beats are raw noise and some fills land on the wrong way.
  task automatic random_access();
    int r;
    logic [SET_INDEX_W-1:0] s;
    logic [WAY_INDEX_W-1:0] w;
    r = $urandom_range(99);
    if ($urandom_range(9) < 7) begin
      s = HOT_SETS[$urandom_range(7)];
    end else begin
      s = SET_INDEX_W'($urandom_range(SETS - 1));
    end
    if (r < 8) begin
      send_beat(1'($urandom_range(1)), SET_INDEX_W'($urandom_range(2047)),
                WAY_INDEX_W'($urandom_range(15)), 1'($urandom_range(1)), 1'b0, '0);
    end else if (r < 50) begin
      send_beat(drrip_pkg::MODE_UPDATE, s, WAY_INDEX_W'($urandom_range(15)), 1'b1,
                1'b0, '0);
    end else begin
      send_beat(drrip_pkg::MODE_VICTIM, s, WAY_INDEX_W'($urandom_range(15)),
                1'($urandom_range(1)), 1'b0, '0);
      w = ($urandom_range(9) == 0) ? WAY_INDEX_W'($urandom_range(15)) : last_victim;
      send_beat(drrip_pkg::MODE_UPDATE, s, w, 1'b0, 1'b0, '0);
    end
  endtask

  // Holds the sender off until every outstanding result has come back.
  task automatic drain_results();
    start <= 1'b0;
    while (pending_choices.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Result beats are compared against the oldest outstanding answer.
  always @(posedge clk) begin : result_check
    choice_t want;
    if (!rst && done === 1'b1) begin
      if (pending_choices.size() == 0) begin
        mism_count++;
        if (mism_count <= 10) begin
          $display("unexpected result beat: way %0d fallback %0d",
                   victim_way, used_fallback);
        end
      end else begin
        want = pending_choices.pop_front();
        if (victim_way !== want.way || used_fallback !== want.fallback) begin
          mism_count++;
          if (mism_count <= 10) begin
            $display("mismatch: way exp %0d got %0d, fallback exp %0d got %0d",
                     want.way, victim_way, want.fallback, used_fallback);
          end
        end
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus
    int i;
    int ph;
    int target;
    int r;
    logic [SET_INDEX_W-1:0] s;
    rst          = 1'b1;
    start        = 1'b0;
    mode         = drrip_pkg::MODE_VICTIM;
    set_index    = '0;
    way_index    = '0;
    was_hit      = 1'b0;
    idle_pct     = 0;
    beats_sent   = 0;
    mism_count   = 0;
    cycle_count  = 0;
    floor_seen   = 1'b0;
    last_victim  = '0;

    // Mirror starts from the reset state of the block.
    for (i = 0; i < SETS * WAYS; i++) begin
      rrpv_mirror[i] = drrip_pkg::RRPV_DISTANT;
      dead_mirror[i] = drrip_pkg::DEAD_CLEAR;
    end
    psel      = SEL_MAX / 2;
    upd_count = '0;
    lfsr      = drrip_pkg::LFSR_SEED;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed table with answers written out.
    foreach (directed_probes[k]) begin
      send_beat(directed_probes[k].op, directed_probes[k].set_no,
                directed_probes[k].way_no, directed_probes[k].hit, 1'b1,
                {directed_probes[k].want_way, directed_probes[k].want_fb});
    end
    drain_results();

    for (ph = 0; ph < 4; ph++) begin
      // Before the last phase, hit the bimodal leader sets until the selector
      // bottoms out, so that followers then insert by the bimodal rule.
      if (ph == 3) begin
        idle_pct = 0;
        while (!floor_seen) begin
          r = $urandom_range(99);
          s = SET_INDEX_W'(SETS - LEADER_SETS + $urandom_range(LEADER_SETS - 1));
          if (r < 85) begin
            send_beat(drrip_pkg::MODE_UPDATE, s, WAY_INDEX_W'($urandom_range(15)),
                      1'b1, 1'b0, '0);
          end else begin
            send_beat(drrip_pkg::MODE_UPDATE, HOT_SETS[$urandom_range(7)],
                      WAY_INDEX_W'($urandom_range(15)), 1'b0, 1'b0, '0);
          end
        end
        drain_results();
      end
      idle_pct = PHASE_IDLE[ph];
      target = beats_sent + PHASE_BEATS;
      while (beats_sent < target) random_access();
      drain_results();
    end

    repeat (8) @(posedge clk);
    if (mism_count == 0 && pending_choices.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/drrip_pkg.sv
rtl/drrip_ctrl.sv
rtl/drrip_dpath.sv
rtl/drrip_dead_block_replacement_core.sv
rtl/drrip_chk.sv
verif/tb.sv
